>>> design/adm6_pkg.sv
// ----------------------------------------------------------------------------
// adm6_pkg
// Shared types and register indexes for the six-axis admittance controller.
// ----------------------------------------------------------------------------
package adm6_pkg;

    localparam int FIELD_AXES = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INERTIA     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DAMPING     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STIFFNESS   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS,
        ST_DV,
        ST_KO,
        ST_DIV,
        ST_HV,
        ST_HA,
        ST_SQSET,
        ST_SQ,
        ST_LIM,
        ST_SQRT,
        ST_SCSET,
        ST_SCMUL,
        ST_SCDIV,
        ST_EMIT
    } state_t;

endpackage

>>> design/admittance_controller_6axis.sv
// ----------------------------------------------------------------------------
// admittance_controller_6axis
// Six-axis admittance law: dead zone, forward-Euler mass-spring-damper step
// and Euclidean speed clamp, built on bit-serial multiply, divide and root.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | set_x..set_yaw, force_x..torque_yaw
// out     | output    | out_valid/out_ready | cmd_x..cmd_yaw, vel_x..vel_yaw
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One item at a time. Enabled: each axis takes four serial multiplies, one
// serial divide and one set-up state; the speed check adds AXES+1 squares
// (the velocities and the limit) and, when the clamp acts, one root and AXES
// multiply-divides. Disabled, an item goes straight to the output state. The
// multiplies share one shift-add multiplier and the divides one restoring
// divider. A finished beat waits in the output register while the next beat
// is accepted. Reset clears offsets and velocities and restores the register
// defaults.
module admittance_controller_6axis #(
    parameter int AXES       = 6,
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [adm6_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [((FRAC_BITS+1 > DATA_WIDTH-1) ? FRAC_BITS+1 : DATA_WIDTH-1)-1:0] cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [DATA_WIDTH-1:0]           set_x,
    input  logic signed [DATA_WIDTH-1:0]           set_y,
    input  logic signed [DATA_WIDTH-1:0]           set_z,
    input  logic signed [DATA_WIDTH-1:0]           set_roll,
    input  logic signed [DATA_WIDTH-1:0]           set_pitch,
    input  logic signed [DATA_WIDTH-1:0]           set_yaw,
    input  logic signed [DATA_WIDTH-1:0]           force_x,
    input  logic signed [DATA_WIDTH-1:0]           force_y,
    input  logic signed [DATA_WIDTH-1:0]           force_z,
    input  logic signed [DATA_WIDTH-1:0]           torque_roll,
    input  logic signed [DATA_WIDTH-1:0]           torque_pitch,
    input  logic signed [DATA_WIDTH-1:0]           torque_yaw,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [DATA_WIDTH-1:0]           cmd_x,
    output logic signed [DATA_WIDTH-1:0]           cmd_y,
    output logic signed [DATA_WIDTH-1:0]           cmd_z,
    output logic signed [DATA_WIDTH-1:0]           cmd_roll,
    output logic signed [DATA_WIDTH-1:0]           cmd_pitch,
    output logic signed [DATA_WIDTH-1:0]           cmd_yaw,
    output logic signed [DATA_WIDTH-1:0]           vel_x,
    output logic signed [DATA_WIDTH-1:0]           vel_y,
    output logic signed [DATA_WIDTH-1:0]           vel_z,
    output logic signed [DATA_WIDTH-1:0]           vel_roll,
    output logic signed [DATA_WIDTH-1:0]           vel_pitch,
    output logic signed [DATA_WIDTH-1:0]           vel_yaw
);
    import adm6_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int MOW  = (F + 1 > W) ? F + 1 : W;
    localparam int PW   = 2 * MOW;
    localparam int NW   = (W + F > 2 * W - 2) ? W + F : 2 * W - 2;
    localparam int MW   = (PW > NW) ? PW : NW;
    localparam int SW   = 2 * W + 2;
    localparam int RW   = W + 1;
    localparam int CW   = $clog2(NW + 2);
    localparam int AXW  = (AXES > 1) ? $clog2(AXES) : 1;

    localparam logic [F:0]   STEP_RST  = (F + 1)'(66);
    localparam logic [W-2:0] ONE_RST   = (W - 1)'(64'd1 << F);
    localparam logic [W-2:0] DZ_RST    = (W - 1)'(((64'd1 << F) + 64'd5) / 64'd10);
    localparam logic [W-2:0] LIM_RST   = {(W - 1){1'b1}};

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] lim;
        logic [W-1:0]  r;
        lim = (MW'(1) << (W - 1)) - MW'(!neg);
        r   = (m > lim) ? lim[W-1:0] : m[W-1:0];
        return neg ? (~r + 1'b1) : r;
    endfunction

    function automatic logic [W-1:0] sat_sum(input logic [W:0] s);
        logic [W-1:0] r;
        if (s[W] != s[W-1])
            r = s[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        else
            r = s[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat_sum({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat_sum({a[W-1], a} - {b[W-1], b});
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic           enable_reg;
    logic [F:0]     step_reg;
    logic [W-2:0]   inertia_reg, damping_reg, stiffness_reg, dz_reg, lim_reg;

    logic [W-1:0]   offs_reg [AXES];
    logic [W-1:0]   vel_reg  [AXES];
    logic [AXW-1:0] ax_reg;
    logic [CW-1:0]  cnt_reg;
    logic           out_valid_reg;

    logic [W-1:0]   set_reg   [FIELD_AXES];
    logic [W-1:0]   force_reg [AXES];
    logic [W-1:0]   acc_reg;

    logic [PW-1:0]  mul_a_reg, prod_reg;
    logic [MOW-1:0] mul_b_reg;
    logic [NW-1:0]  num_reg, quo_reg;
    logic [W:0]     rem_reg, den_reg;
    logic [SW-1:0]  sum_reg, rad_reg;
    logic [RW:0]    sq_rem_reg;
    logic [RW-1:0]  root_reg;

    logic [W-1:0]   cmd_reg  [FIELD_AXES];
    logic [W-1:0]   vout_reg [FIELD_AXES];

    logic [W-1:0]   set_in [FIELD_AXES];
    logic [W-1:0]   force_in [FIELD_AXES];

    assign set_in[0] = set_x;
    assign set_in[1] = set_y;
    assign set_in[2] = set_z;
    assign set_in[3] = set_roll;
    assign set_in[4] = set_pitch;
    assign set_in[5] = set_yaw;
    assign force_in[0] = force_x;
    assign force_in[1] = force_y;
    assign force_in[2] = force_z;
    assign force_in[3] = torque_roll;
    assign force_in[4] = torque_pitch;
    assign force_in[5] = torque_yaw;

    // ------------------------------------------------------------------
    // per-axis operands
    // ------------------------------------------------------------------
    logic           in_fire, done, last_ax, can_emit, over_lim;
    logic [W-1:0]   o_cur, v_cur, f_cur, f_dz, pmul;
    logic [W-1:0]   inertia_eff;
    logic [MW-1:0]  pshift;
    logic [W+1:0]   r2;
    logic           r2_ge;
    logic [RW+2:0]  sq_r2, sq_trial;
    logic           sq_ge;

    always_comb
    begin
        in_fire     = in_valid && in_ready;
        done        = (cnt_reg == CW'(0));
        last_ax     = (ax_reg == AXW'(AXES - 1));
        can_emit    = !out_valid_reg || out_ready;
        over_lim    = (sum_reg > SW'(prod_reg));
        o_cur       = offs_reg[ax_reg];
        v_cur       = vel_reg[ax_reg];
        f_cur       = force_reg[ax_reg];
        // drop forces inside the dead zone
        f_dz        = (mag_of(f_cur) < W'(dz_reg)) ? '0 : f_cur;
        inertia_eff = (inertia_reg == '0) ? W'(1) : W'(inertia_reg);
        pshift      = MW'(prod_reg >> F);
        pmul        = '0;
        unique case (state_reg)
            ST_DV, ST_HV: pmul = sat_mag(v_cur[W-1], pshift);
            ST_KO:        pmul = sat_mag(o_cur[W-1], pshift);
            ST_HA:        pmul = sat_mag(acc_reg[W-1], pshift);
            default:      pmul = '0;
        endcase
        r2       = {rem_reg, num_reg[NW-1]};
        r2_ge    = (r2 >= {1'b0, den_reg});
        sq_r2    = {sq_rem_reg, rad_reg[SW-1:SW-2]};
        sq_trial = {1'b0, root_reg, 2'b01};
        sq_ge    = (sq_r2 >= sq_trial);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = enable_reg ? ST_AXIS : ST_EMIT;
            ST_AXIS:  state_next = ST_DV;
            ST_DV:    if (done) state_next = ST_KO;
            ST_KO:    if (done) state_next = ST_DIV;
            ST_DIV:   if (done) state_next = ST_HV;
            ST_HV:    if (done) state_next = ST_HA;
            ST_HA:    if (done) state_next = last_ax ? ST_SQSET : ST_AXIS;
            ST_SQSET: state_next = ST_SQ;
            ST_SQ:    if (done) state_next = last_ax ? ST_LIM : ST_SQSET;
            ST_LIM:   if (done) state_next = over_lim ? ST_SQRT : ST_EMIT;
            ST_SQRT:  if (done) state_next = ST_SCSET;
            ST_SCSET: state_next = ST_SCMUL;
            ST_SCMUL: if (done) state_next = ST_SCDIV;
            ST_SCDIV: if (done) state_next = last_ax ? ST_EMIT : ST_SCSET;
            ST_EMIT:  if (can_emit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // control and state stores
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            step_reg      <= STEP_RST;
            inertia_reg   <= ONE_RST;
            damping_reg   <= ONE_RST;
            stiffness_reg <= ONE_RST;
            dz_reg        <= DZ_RST;
            lim_reg       <= LIM_RST;
            ax_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                offs_reg[i] <= '0;
                vel_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ENABLE:      enable_reg    <= cfg_data[0];
                    REG_STEP_SIZE:   step_reg      <= cfg_data[F:0];
                    REG_INERTIA:     inertia_reg   <= cfg_data[W-2:0];
                    REG_DAMPING:     damping_reg   <= cfg_data[W-2:0];
                    REG_STIFFNESS:   stiffness_reg <= cfg_data[W-2:0];
                    REG_DEAD_ZONE:   dz_reg        <= cfg_data[W-2:0];
                    REG_SPEED_LIMIT: lim_reg       <= cfg_data[W-2:0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;

            if (!done)
                cnt_reg <= cnt_reg - 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    ax_reg <= '0;
                    if (in_fire && !enable_reg)
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            offs_reg[i] <= '0;
                            vel_reg[i]  <= '0;
                        end
                    end
                end
                ST_AXIS, ST_SQSET, ST_SCSET:
                    cnt_reg <= CW'(MOW);
                ST_DV, ST_DIV:
                    if (done) cnt_reg <= (state_reg == ST_DV) ? CW'(MOW) : CW'(MOW);
                ST_KO:
                    if (done) cnt_reg <= CW'(NW);
                ST_HV:
                    if (done)
                    begin
                        offs_reg[ax_reg] <= sadd(o_cur, pmul);
                        cnt_reg          <= CW'(MOW);
                    end
                ST_HA:
                    if (done)
                    begin
                        vel_reg[ax_reg] <= sadd(v_cur, pmul);
                        ax_reg          <= last_ax ? '0 : ax_reg + 1'b1;
                    end
                ST_SQ:
                    if (done)
                    begin
                        if (last_ax)
                            cnt_reg <= CW'(MOW);
                        ax_reg <= last_ax ? '0 : ax_reg + 1'b1;
                    end
                ST_LIM:
                    if (done && over_lim) cnt_reg <= CW'(RW);
                ST_SQRT:
                    if (done) ax_reg <= '0;
                ST_SCMUL:
                    if (done) cnt_reg <= CW'(NW);
                ST_SCDIV:
                    if (done)
                    begin
                        vel_reg[ax_reg] <= sat_mag(v_cur[W-1], MW'(quo_reg));
                        ax_reg          <= last_ax ? '0 : ax_reg + 1'b1;
                    end
                ST_EMIT:
                    if (can_emit) out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // serial datapath: shift-add multiply, restoring divide and root
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < FIELD_AXES; i++)
                set_reg[i] <= set_in[i];
            for (int i = 0; i < AXES; i++)
                force_reg[i] <= force_in[i];
        end

        if (!done)
        begin
            case (state_reg) inside
                ST_DV, ST_KO, ST_HV, ST_HA, ST_SQ, ST_LIM, ST_SCMUL:
                begin
                    if (mul_b_reg[0])
                        prod_reg <= prod_reg + mul_a_reg;
                    mul_a_reg <= mul_a_reg << 1;
                    mul_b_reg <= mul_b_reg >> 1;
                end
                ST_DIV, ST_SCDIV:
                begin
                    rem_reg <= r2_ge ? (W+1)'(r2 - {1'b0, den_reg}) : r2[W:0];
                    num_reg <= num_reg << 1;
                    quo_reg <= {quo_reg[NW-2:0], r2_ge};
                end
                ST_SQRT:
                begin
                    sq_rem_reg <= sq_ge ? (RW+1)'(sq_r2 - sq_trial) : sq_r2[RW:0];
                    rad_reg    <= rad_reg << 2;
                    root_reg   <= {root_reg[RW-2:0], sq_ge};
                end
                default: ;
            endcase
        end
        else
        begin
            case (state_reg)
                ST_AXIS:
                begin
                    mul_a_reg <= PW'(damping_reg);
                    mul_b_reg <= MOW'(mag_of(v_cur));
                    prod_reg  <= '0;
                end
                ST_DV:
                begin
                    acc_reg   <= ssub(f_dz, pmul);
                    mul_a_reg <= PW'(stiffness_reg);
                    mul_b_reg <= MOW'(mag_of(o_cur));
                    prod_reg  <= '0;
                end
                ST_KO:
                begin
                    acc_reg <= ssub(acc_reg, pmul);
                    num_reg <= NW'(mag_of(ssub(acc_reg, pmul))) << F;
                    den_reg <= (W+1)'(inertia_eff);
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
                ST_DIV:
                begin
                    acc_reg   <= sat_mag(acc_reg[W-1], MW'(quo_reg));
                    mul_a_reg <= PW'(step_reg);
                    mul_b_reg <= MOW'(mag_of(v_cur));
                    prod_reg  <= '0;
                end
                ST_HV:
                begin
                    mul_a_reg <= PW'(step_reg);
                    mul_b_reg <= MOW'(mag_of(acc_reg));
                    prod_reg  <= '0;
                end
                ST_HA:
                    if (last_ax) sum_reg <= '0;
                ST_SQSET, ST_SCSET:
                begin
                    mul_a_reg <= (state_reg == ST_SQSET) ? PW'(mag_of(v_cur)) : PW'(lim_reg);
                    mul_b_reg <= MOW'(mag_of(v_cur));
                    prod_reg  <= '0;
                end
                ST_SQ:
                begin
                    sum_reg   <= sum_reg + SW'(prod_reg);
                    mul_a_reg <= PW'(lim_reg);
                    mul_b_reg <= MOW'(lim_reg);
                    prod_reg  <= '0;
                end
                ST_LIM:
                begin
                    rad_reg    <= sum_reg;
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                end
                ST_SCMUL:
                begin
                    num_reg <= NW'(prod_reg);
                    den_reg <= root_reg;
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
                ST_EMIT:
                    if (can_emit)
                    begin
                        for (int i = 0; i < FIELD_AXES; i++)
                        begin
                            if (i < AXES)
                            begin
                                cmd_reg[i]  <= sadd(set_reg[i], offs_reg[i]);
                                vout_reg[i] <= vel_reg[i];
                            end
                            else
                            begin
                                cmd_reg[i]  <= set_reg[i];
                                vout_reg[i] <= '0;
                            end
                        end
                    end
                default: ;
            endcase
        end
    end

    assign cmd_x     = cmd_reg[0];
    assign cmd_y     = cmd_reg[1];
    assign cmd_z     = cmd_reg[2];
    assign cmd_roll  = cmd_reg[3];
    assign cmd_pitch = cmd_reg[4];
    assign cmd_yaw   = cmd_reg[5];
    assign vel_x     = vout_reg[0];
    assign vel_y     = vout_reg[1];
    assign vel_z     = vout_reg[2];
    assign vel_roll  = vout_reg[3];
    assign vel_pitch = vout_reg[4];
    assign vel_yaw   = vout_reg[5];

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Admittance controller testbench
// Drives control ticks over the valid/ready input channel, predicts the pose
// and velocity of each tick with its own fixed-point model of the damped
// spring step, dead zone and speed clamp, and compares every output beat.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adm6_pkg::*;

    localparam int  DW        = 32;
    localparam int  FB        = 16;
    localparam int  NAX       = 6;
    localparam int  CFG_W     = 31;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef logic signed [DW-1:0] word_t;
    typedef struct {
        word_t cmd [NAX];
        word_t vel [NAX];
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    word_t set_v [NAX];
    word_t frc_v [NAX];
    word_t cmd_v [NAX];
    word_t vel_v [NAX];

    initial begin
        for (int i = 0; i < NAX; i++)
        begin
            set_v[i] = '0;
            frc_v[i] = '0;
        end
    end

    always #10 clk = ~clk;

    admittance_controller_6axis u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .set_x(set_v[0]), .set_y(set_v[1]), .set_z(set_v[2]),
        .set_roll(set_v[3]), .set_pitch(set_v[4]), .set_yaw(set_v[5]),
        .force_x(frc_v[0]), .force_y(frc_v[1]), .force_z(frc_v[2]),
        .torque_roll(frc_v[3]), .torque_pitch(frc_v[4]), .torque_yaw(frc_v[5]),
        .out_valid(out_valid), .out_ready(out_ready),
        .cmd_x(cmd_v[0]), .cmd_y(cmd_v[1]), .cmd_z(cmd_v[2]),
        .cmd_roll(cmd_v[3]), .cmd_pitch(cmd_v[4]), .cmd_yaw(cmd_v[5]),
        .vel_x(vel_v[0]), .vel_y(vel_v[1]), .vel_z(vel_v[2]),
        .vel_roll(vel_v[3]), .vel_pitch(vel_v[4]), .vel_yaw(vel_v[5])
    );

    // predictor state and register copy
    logic [CFG_W-1:0] reg_copy [7];
    longint offs [NAX];
    longint vels [NAX];
    pose_t  pending_poses [$];
    int     fail_count = 0;
    longint cycles = 0;
    bit     hold_off = 1'b0;

    function automatic longint clip(longint a);
        if (a > SAT_HI) return SAT_HI;
        if (a < SAT_LO) return SAT_LO;
        return a;
    endfunction

    function automatic longint mag_to_val(bit neg, logic [127:0] m);
        logic [127:0] lim;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [63:0] absval(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [127:0] p;
        p = 128'(absval(a)) * 128'(absval(b));
        return mag_to_val((a < 0) != (b < 0), p >> FB);
    endfunction

    function automatic longint q_div(longint a, logic [63:0] d);
        logic [127:0] n;
        n = 128'(absval(a)) << FB;
        return mag_to_val(a < 0, n / 128'(d));
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0] r, c;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    task automatic advance_admittance(input word_t sp [NAX], input word_t fr [NAX],
                                      output pose_t res);
        longint h, d, k, f, acc;
        logic [63:0] m, dz, lim, nrm;
        longint no [NAX];
        longint nv [NAX];
        logic [127:0] sum;
        if (reg_copy[REG_ENABLE] == 0)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                offs[i] = 0;
                vels[i] = 0;
            end
        end
        else
        begin
            h = reg_copy[REG_STEP_SIZE];
            m = reg_copy[REG_INERTIA] != 0 ? 64'(reg_copy[REG_INERTIA]) : 64'd1;
            d = reg_copy[REG_DAMPING];
            k = reg_copy[REG_STIFFNESS];
            dz = reg_copy[REG_DEAD_ZONE];
            lim = reg_copy[REG_SPEED_LIMIT];
            sum = 0;
            for (int i = 0; i < NAX; i++)
            begin
                f = longint'(fr[i]);
                if (absval(f) < dz) f = 0;
                acc = clip(clip(f - q_mul(d, vels[i])) - q_mul(k, offs[i]));
                acc = q_div(acc, m);
                no[i] = clip(offs[i] + q_mul(h, vels[i]));
                nv[i] = clip(vels[i] + q_mul(h, acc));
                sum += 128'(absval(nv[i])) * 128'(absval(nv[i]));
            end
            if (sum > 128'(lim) * 128'(lim))
            begin
                nrm = root_floor(sum);
                for (int i = 0; i < NAX; i++)
                    nv[i] = mag_to_val(nv[i] < 0,
                                       (128'(absval(nv[i])) * 128'(lim)) / 128'(nrm));
            end
            for (int i = 0; i < NAX; i++)
            begin
                offs[i] = no[i];
                vels[i] = nv[i];
            end
        end
        for (int i = 0; i < NAX; i++)
        begin
            res.cmd[i] = word_t'(clip(longint'(sp[i]) + offs[i]));
            res.vel[i] = word_t'(vels[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        fail_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        reg_copy[idx] = CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input word_t sp [NAX], input word_t fr [NAX]);
        pose_t p;
        idle_gap();
        @(posedge clk);
        in_valid <= 1'b1;
        for (int i = 0; i < NAX; i++)
        begin
            set_v[i] <= sp[i];
            frc_v[i] <= fr[i];
        end
        do @(posedge clk); while (!in_ready);
        advance_admittance(sp, fr, p);
        pending_poses.push_back(p);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return word_t'(SAT_HI);
            1: return word_t'(SAT_LO);
            2: return word_t'($urandom_range(0, 400000)) - 200000;
            3: return word_t'($urandom_range(0, 20000)) - 10000;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        word_t sp [NAX];
        word_t fr [NAX];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                sp[i] = rand_word();
                fr[i] = ($urandom_range(0, 3) == 0) ? rand_word()
                        : word_t'($urandom_range(0, 1600000)) - 800000;
            end
            send_tick(sp, fr);
        end
    endtask

    task automatic test_disabled();
        word_t sp [NAX];
        word_t fr [NAX];
        for (int i = 0; i < NAX; i++)
        begin
            sp[i] = (i % 2) ? word_t'(SAT_HI) : word_t'(SAT_LO);
            fr[i] = word_t'(SAT_HI);
        end
        send_tick(sp, fr);
        send_random(3);
        drain();
    endtask

    task automatic test_directed();
        word_t sp [NAX];
        word_t fr [NAX];
        write_reg(REG_ENABLE, 1);
        // dead zone edges and extremes with default gains
        for (int t = 0; t < 6; t++)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                sp[i] = (t == 2) ? word_t'(SAT_HI) : word_t'(i * 1000);
                case (t)
                    0: fr[i] = word_t'(6553);
                    1: fr[i] = -word_t'(6554);
                    2: fr[i] = word_t'(SAT_HI);
                    3: fr[i] = word_t'(SAT_LO);
                    default: fr[i] = word_t'(65536 * (i + 1));
                endcase
            end
            send_tick(sp, fr);
        end
        drain();
        // saturated command: big offsets pushed by big step and force
        write_reg(REG_STEP_SIZE, 65536);
        write_reg(REG_INERTIA, 0);
        write_reg(REG_DAMPING, 0);
        write_reg(REG_STIFFNESS, 0);
        write_reg(REG_DEAD_ZONE, 0);
        for (int t = 0; t < 5; t++)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                sp[i] = (i < 3) ? word_t'(SAT_HI) : word_t'(SAT_LO);
                fr[i] = (i < 3) ? word_t'(SAT_HI) : word_t'(SAT_LO);
            end
            send_tick(sp, fr);
        end
        drain();
        // speed clamp with zero and small limits
        write_reg(REG_INERTIA, 65536);
        write_reg(REG_SPEED_LIMIT, 0);
        send_random(3);
        drain();
        write_reg(REG_SPEED_LIMIT, 65536);
        send_random(4);
        drain();
        // zero step freezes state
        write_reg(REG_STEP_SIZE, 0);
        send_random(3);
        drain();
    endtask

    task automatic test_random_sweep();
        for (int ph = 0; ph < 9; ph++)
        begin
            write_reg(REG_ENABLE, (ph == 4) ? 0 : 1);
            write_reg(REG_STEP_SIZE, ph == 0 ? 1 : ph == 1 ? 65536 : $urandom_range(1, 8000));
            write_reg(REG_INERTIA, ph == 2 ? 31'h7FFFFFFF : $urandom_range(1, 300000));
            write_reg(REG_DAMPING, ph == 3 ? 31'h7FFFFFFF : $urandom_range(0, 400000));
            write_reg(REG_STIFFNESS, ph == 5 ? 31'h7FFFFFFF : $urandom_range(0, 400000));
            write_reg(REG_DEAD_ZONE, ph == 6 ? 31'h7FFFFFFF : $urandom_range(0, 100000));
            write_reg(REG_SPEED_LIMIT, ph == 7 ? 31'h7FFFFFFF : $urandom_range(0, 2000000));
            if (ph == 8) hold_off = 1'b1;
            send_random(100);
            drain();
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (4000) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                    : $urandom_range(0, 2);
                if ($urandom_range(0, 2) == 0) n = 0;
                if (n != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    // compare each output beat with the oldest predicted pose
    always @(posedge clk)
    begin
        pose_t want;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
                report_mismatch("beat with nothing pending, cmd[0]", cmd_v[0], '0);
            else
            begin
                want = pending_poses.pop_front();
                for (int i = 0; i < NAX; i++)
                begin
                    if (cmd_v[i] !== want.cmd[i])
                        report_mismatch($sformatf("cmd[%0d]", i), cmd_v[i], want.cmd[i]);
                    if (vel_v[i] !== want.vel[i])
                        report_mismatch($sformatf("vel[%0d]", i), vel_v[i], want.vel[i]);
                end
            end
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        reg_copy[REG_ENABLE]      = 0;
        reg_copy[REG_STEP_SIZE]   = 66;
        reg_copy[REG_INERTIA]     = 65536;
        reg_copy[REG_DAMPING]     = 65536;
        reg_copy[REG_STIFFNESS]   = 65536;
        reg_copy[REG_DEAD_ZONE]   = 6554;
        reg_copy[REG_SPEED_LIMIT] = 31'h7FFFFFFF;
        for (int i = 0; i < NAX; i++)
        begin
            offs[i] = 0;
            vels[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_disabled();
        test_directed();
        test_random_sweep();
        if (pending_poses.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
